// ----- src/delta_of_delta_encoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// delta_of_delta_encoder_core_macros
// assertion macros shared by the checker of the delta-of-delta encoder
// ----------------------------------------------------------------------------
`ifndef DELTA_OF_DELTA_ENCODER_CORE_MACROS_SVH
`define DELTA_OF_DELTA_ENCODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DDE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define DDE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dde_pkg.sv -----
// ----------------------------------------------------------------------------
// dde_pkg
// types, codes and helpers shared by the delta-of-delta encoder modules
// ----------------------------------------------------------------------------
package dde_pkg;

  // element width codes
  localparam logic [1:0] ELW_16 = 2'd0;
  localparam logic [1:0] ELW_32 = 2'd1;
  localparam logic [1:0] ELW_64 = 2'd2;

  // what the back end has to write for one request
  typedef enum logic [2:0] {
    KIND_NONE,   // nothing to write
    KIND_BIT0,   // a single 0 bit
    KIND_NULL6,  // null marker 111111
    KIND_WIDE,   // 1 bit plus zigzag value at element width
    KIND_DOD     // prefix-coded delta of delta
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] val;   // zigzag value for wide, raw delta of delta for dod
    logic [1:0]  elw;
    logic        last;
    logic        err;
  } entry_t;

  function automatic logic [63:0] zigzag(input logic [63:0] v);
    return (v << 1) ^ {64{v[63]}};
  endfunction

endpackage

// ----- src/dde_front.sv -----
// ----------------------------------------------------------------------------
// dde_front
// takes samples, tracks header / delta state and classifies each request
// ----------------------------------------------------------------------------
module dde_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [63:0]       in_sample_i,
  input  logic              in_last_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output dde_pkg::entry_t   push_entry_o
);

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_STEADY = 2'd2;

  logic [1:0]  elw_q;
  logic [1:0]  phase_q, phase_d;
  logic        err_q, err_d;
  logic [63:0] pv_q, pv_d;
  logic [63:0] pd_q, pd_d;

  logic [63:0] sx;
  logic        is_null;
  logic [64:0] d65;
  logic [65:0] dd66;
  logic        d_fit64, d_fitw, dd_fit;
  logic        accept;
  dde_pkg::kind_e kind;
  logic [63:0] val;

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;

  always_comb begin
    case (elw_q)
      dde_pkg::ELW_16: begin
        sx      = {{48{in_sample_i[15]}}, in_sample_i[15:0]};
        is_null = in_sample_i[15:0] == {1'b1, 15'd0};
      end
      dde_pkg::ELW_32: begin
        sx      = {{32{in_sample_i[31]}}, in_sample_i[31:0]};
        is_null = in_sample_i[31:0] == {1'b1, 31'd0};
      end
      default: begin
        sx      = in_sample_i;
        is_null = in_sample_i == {1'b1, 63'd0};
      end
    endcase
  end

  // pv_q holds the header in the first-delta phase and the previous value after
  assign d65  = {sx[63], sx} - {pv_q[63], pv_q};
  assign dd66 = {{2{sx[63]}}, sx} - {{2{pv_q[63]}}, pv_q} - {{2{pd_q[63]}}, pd_q};
  assign d_fit64 = d65[64] == d65[63];
  assign dd_fit  = (dd66[65] == dd66[64]) && (dd66[64] == dd66[63]);

  always_comb begin
    case (elw_q)
      dde_pkg::ELW_16: d_fitw = d65[64:15] == {50{d65[15]}};
      dde_pkg::ELW_32: d_fitw = d65[64:31] == {34{d65[31]}};
      default:         d_fitw = d_fit64;
    endcase
  end

  always_comb begin
    kind    = dde_pkg::KIND_NONE;
    val     = '0;
    err_d   = err_q;
    phase_d = phase_q;
    pv_d    = pv_q;
    pd_d    = pd_q;
    if (!err_q) begin
      case (phase_q)
        PHASE_HEADER: begin
          if (is_null) begin
            kind = dde_pkg::KIND_BIT0;
          end else begin
            kind    = dde_pkg::KIND_WIDE;
            val     = dde_pkg::zigzag(sx);
            pv_d    = sx;
            phase_d = PHASE_FIRST;
          end
        end
        PHASE_FIRST: begin
          if (is_null) begin
            kind = dde_pkg::KIND_BIT0;
          end else if (!d_fit64 || !d_fitw) begin
            err_d = 1'b1;
          end else begin
            kind    = dde_pkg::KIND_WIDE;
            val     = dde_pkg::zigzag(d65[63:0]);
            pv_d    = sx;
            pd_d    = d65[63:0];
            phase_d = PHASE_STEADY;
          end
        end
        default: begin
          if (is_null) begin
            kind = dde_pkg::KIND_NULL6;
          end else if (!d_fit64 || !dd_fit) begin
            err_d = 1'b1;
          end else begin
            kind = (dd66[63:0] == 64'd0) ? dde_pkg::KIND_BIT0 : dde_pkg::KIND_DOD;
            val  = dd66[63:0];
            pv_d = sx;
            pd_d = d65[63:0];
          end
        end
      endcase
    end
  end

  assign push_valid_o      = accept && ((kind != dde_pkg::KIND_NONE) || in_last_i);
  assign push_entry_o.kind = kind;
  assign push_entry_o.val  = val;
  assign push_entry_o.elw  = elw_q;
  assign push_entry_o.last = in_last_i;
  assign push_entry_o.err  = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elw_q   <= dde_pkg::ELW_64;
      phase_q <= PHASE_HEADER;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        elw_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (in_last_i) begin
          phase_q <= PHASE_HEADER;
          err_q   <= 1'b0;
        end else begin
          phase_q <= phase_d;
          err_q   <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_last_i) begin
      pv_q <= pv_d;
      pd_q <= pd_d;
    end
  end

endmodule

// ----- src/dde_fifo.sv -----
// ----------------------------------------------------------------------------
// dde_fifo
// short request queue between the classifier and the bit packer
// ----------------------------------------------------------------------------
module dde_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  dde_pkg::entry_t   push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output dde_pkg::entry_t   pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dde_pkg::entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/dde_back.sv -----
// ----------------------------------------------------------------------------
// dde_back
// turns queued requests into bit pieces and packs them msb first into words
// ----------------------------------------------------------------------------
module dde_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  dde_pkg::entry_t   head_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [63:0]       m_data_o,
  output logic              m_last_o,
  output logic              m_err_o
);

  // close marker: 111110, 64 ones, one 0 bit
  localparam logic [70:0] CloseBits = {6'b111110, {64{1'b1}}, 1'b0};
  localparam logic [6:0]  CloseLen  = 7'd71;

  // format stage
  logic        sub_q;
  logic        pc_valid_q;
  logic [70:0] pc_bits_q;
  logic [6:0]  pc_len_q;
  logic        pc_flush_q, pc_err_q;

  logic [63:0] c;
  logic [70:0] code_bits, piece_bits;
  logic [6:0]  code_len, piece_len;
  logic        piece_flush, done, fmt_fire;

  // packer
  logic [191:0] acc_q, acc_d, acc_base, placed;
  logic [7:0]   cnt_q, cnt_d, base, shl;
  logic         flush_q, err_q;
  logic         out_free, pop_full, emit_last, pk_take;
  logic         m_valid_q, m_last_q, m_err_q;
  logic [63:0]  m_data_q;

  assign c = dde_pkg::zigzag(head_i.val) - 64'd1;

  always_comb begin
    code_bits = '0;
    code_len  = 7'd1;
    case (head_i.kind)
      dde_pkg::KIND_NULL6: begin
        code_bits = {65'd0, 6'b111111};
        code_len  = 7'd6;
      end
      dde_pkg::KIND_WIDE: begin
        case (head_i.elw)
          dde_pkg::ELW_16: begin
            code_bits = {54'd0, 1'b1, head_i.val[15:0]};
            code_len  = 7'd17;
          end
          dde_pkg::ELW_32: begin
            code_bits = {38'd0, 1'b1, head_i.val[31:0]};
            code_len  = 7'd33;
          end
          default: begin
            code_bits = {6'd0, 1'b1, head_i.val};
            code_len  = 7'd65;
          end
        endcase
      end
      dde_pkg::KIND_DOD: begin
        if (c[63:7] == '0) begin
          code_bits = {62'd0, 2'b10, c[6:0]};
          code_len  = 7'd9;
        end else if (c[63:9] == '0) begin
          code_bits = {59'd0, 3'b110, c[8:0]};
          code_len  = 7'd12;
        end else if (c[63:16] == '0) begin
          code_bits = {51'd0, 4'b1110, c[15:0]};
          code_len  = 7'd20;
        end else if (c[63:32] == '0) begin
          code_bits = {34'd0, 5'b11110, c[31:0]};
          code_len  = 7'd37;
        end else begin
          code_bits = {1'b0, 6'b111110, c};
          code_len  = 7'd70;
        end
      end
      default: begin
        code_bits = '0;
        code_len  = 7'd1;
      end
    endcase
  end

  // a last request sends its code first, then the close marker
  always_comb begin
    if (!sub_q && (head_i.kind != dde_pkg::KIND_NONE)) begin
      piece_bits  = code_bits;
      piece_len   = code_len;
      piece_flush = 1'b0;
      done        = !head_i.last;
    end else begin
      piece_bits  = CloseBits;
      piece_len   = CloseLen;
      piece_flush = 1'b1;
      done        = 1'b1;
    end
  end

  assign fmt_fire = head_valid_i && (!pc_valid_q || pk_take);
  assign pop_o    = fmt_fire && done;

  // packer: acc_q holds cnt_q pending bits left aligned
  assign out_free  = !m_valid_q || m_ready_i;
  assign pop_full  = out_free && (cnt_q[7:6] != 2'd0);
  assign emit_last = out_free && flush_q && (cnt_q[7:6] == 2'd0);

  always_comb begin
    if (emit_last) begin
      acc_base = '0;
      base     = '0;
    end else if (pop_full) begin
      acc_base = acc_q << 64;
      base     = cnt_q - 8'd64;
    end else begin
      acc_base = acc_q;
      base     = cnt_q;
    end
  end

  assign pk_take = pc_valid_q && (!flush_q || emit_last) && (base[7:6] == 2'd0);
  assign shl     = 8'd71 - {1'b0, pc_len_q};
  assign placed  = ({pc_bits_q, 121'd0} << shl) >> base;
  assign acc_d   = acc_base | (pk_take ? placed : '0);
  assign cnt_d   = base + (pk_take ? {1'b0, pc_len_q} : 8'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q      <= 1'b0;
      pc_valid_q <= 1'b0;
      acc_q      <= '0;
      cnt_q      <= '0;
      flush_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (fmt_fire) begin
        pc_valid_q <= 1'b1;
        sub_q      <= !done;
      end else if (pk_take) begin
        pc_valid_q <= 1'b0;
      end
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (pk_take) begin
        flush_q <= pc_flush_q;
      end else if (emit_last) begin
        flush_q <= 1'b0;
      end
      if (out_free) begin
        m_valid_q <= pop_full || emit_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fmt_fire) begin
      pc_bits_q  <= piece_bits;
      pc_len_q   <= piece_len;
      pc_flush_q <= piece_flush;
      pc_err_q   <= head_i.err;
    end
    if (pk_take) begin
      err_q <= pc_err_q;
    end
    if (out_free) begin
      m_data_q <= acc_q[191:128];
      m_last_q <= emit_last;
      m_err_q  <= err_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;
  assign m_err_o   = m_err_q;

endmodule

// ----- src/delta_of_delta_encoder_core.sv -----
// ----------------------------------------------------------------------------
// delta_of_delta_encoder_core
// delta-of-delta encoder packing a prefix-coded bit stream into 64-bit words
// ----------------------------------------------------------------------------
// channel   dir  tdata             tlast       tuser
// s_axis    in   sample [63:0]     block_end   -
// m_axis    out  packed_word       word_last   overflow_error
// cfg       in   element_width on cfg_wdata_i, written when cfg_we_i is high
//
// one sample per cycle while each code completes at most one output word and
// the output is ready; a code completing two words stalls the packer while
// the first is emitted. a last sample sends its code, then the close marker,
// or only the close if it has no code; the close holds the packer until the
// final word leaves. input stalls only when the QueueDepth-entry request queue
// is full. reset clears all control state; no memory needs a clearing pass.
// ----------------------------------------------------------------------------
module delta_of_delta_encoder_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,    // element_width
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i, // [63:0] sample
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o, // [63:0] packed_word
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o  // [0] overflow_error
);

  logic            push_valid, push_ready;
  dde_pkg::entry_t push_entry;
  logic            head_valid, head_pop;
  dde_pkg::entry_t head_entry;

  dde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_sample_i  (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  dde_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_entry),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_data_o   (head_entry)
  );

  dde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (head_pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o),
    .m_err_o      (m_axis_tuser_o)
  );

endmodule

// ----- src/dde_checker.sv -----
// ----------------------------------------------------------------------------
// dde_checker
// port-level checks of the delta-of-delta encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "delta_of_delta_encoder_core_macros.svh"

module dde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  logic        m_stall;
  logic        m_last_beat;
  logic [65:0] m_bus;
  assign m_stall     = m_axis_tvalid_o && !m_axis_tready_i;
  assign m_last_beat = m_axis_tvalid_o && m_axis_tlast_o;
  assign m_bus       = {m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o};

  `DDE_ASSERT_NXT(a_out_valid_held, clk_i, rst_ni, m_stall, m_axis_tvalid_o, "valid dropped")

  `DDE_ASSERT_NXT(a_out_data_held, clk_i, rst_ni, m_stall, $stable(m_bus), "output not held")

  // the close marker ends in a 0 bit, so the final word never has its lsb set
  `DDE_ASSERT_NOW(a_last_lsb_clear, clk_i, rst_ni, m_last_beat, !m_axis_tdata_o[0], "final lsb set")

  // a word needs at least one accepted sample, none can be shown right after reset
  `DDE_ASSERT_NOW(a_rst_idle, clk_i, rst_ni, !$past(rst_ni), !m_axis_tvalid_o, "valid after reset")

endmodule

bind delta_of_delta_encoder_core dde_checker u_dde_checker (.*);
